[design/lzwc_pkg.sv]
// Package with the constants and state type of the LZW compressor core.
package lzwc_pkg;

	localparam int CODE_BITS  = 12;
	localparam int BYTE_BITS  = 8;
	localparam int ENTRY_BITS = CODE_BITS + BYTE_BITS;
	localparam int NF_BITS    = CODE_BITS + 1;
	localparam int DICT_DEPTH = 1 << CODE_BITS;
	localparam int FIRST_FREE = 256;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MISS,
		ST_FLUSH
	} lzwc_state_t;

endpackage

[design/lzw_compressor_core.sv]
// LZW compressor with a linearly searched dictionary and fixed-width code words.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------
//  byte    | byte_valid, byte_stall | data_byte[7:0], end_of_stream
//  code    | code_valid, code_stall | code[11:0], final_res
//
// A searching item compares dictionary entries in turn (up to 3840) before its result word, if
// any, is loaded; an item with no search (first byte, or an empty dictionary) skips the compare
// and goes straight to its result word, if any. The dictionary's single read port gives one entry a cycle.
// Reset clears the control state; the dictionary needs no clearing, since only entries
// written in the current stream are searched. A stalled output word holds the block
// before its next result word, but an item may be taken while a word waits.
module lzw_compressor_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            byte_valid,
	output logic                            byte_stall,
	input  logic [lzwc_pkg::BYTE_BITS-1:0]  data_byte,
	input  logic                            end_of_stream,
	output logic                            code_valid,
	input  logic                            code_stall,
	output logic [lzwc_pkg::CODE_BITS-1:0]  code,
	output logic                            final_res
);
	import lzwc_pkg::*;

	lzwc_state_t state_q, state_d;

	logic [ENTRY_BITS-1:0] dict_mem [DICT_DEPTH];
	logic [ENTRY_BITS-1:0] rd_s1;
	logic                  cmp_v_s1;
	logic [NF_BITS-1:0]    cmp_idx_s1;

	logic [BYTE_BITS-1:0]  byte_q;
	logic                  eos_q;
	logic [CODE_BITS-1:0]  cur_q;
	logic                  have_q;
	logic [NF_BITS-1:0]    nf_q;
	logic [NF_BITS-1:0]    addr_q;
	logic                  out_valid_q;
	logic [CODE_BITS-1:0]  code_q;
	logic                  final_q;

	logic                  acc;
	logic                  issue;
	logic                  hit;
	logic                  last;
	logic                  out_free;
	logic                  ld_miss;
	logic                  ld_flush;
	logic                  wr_en;
	logic [ENTRY_BITS-1:0] key;

	assign key      = {cur_q, byte_q};
	assign out_free = !out_valid_q || !code_stall;
	assign issue    = (state_q == ST_SEARCH) && (addr_q < nf_q);
	assign hit      = (state_q == ST_SEARCH) && cmp_v_s1 && (rd_s1 == key);
	assign last     = cmp_v_s1 && (cmp_idx_s1 == nf_q - NF_BITS'(1));
	assign ld_miss  = (state_q == ST_MISS) && out_free;
	assign ld_flush = (state_q == ST_FLUSH) && out_free;
	assign wr_en    = ld_miss && (nf_q < NF_BITS'(DICT_DEPTH));

	always_comb begin
		state_d    = state_q;
		byte_stall = (state_q != ST_IDLE);
		acc        = byte_valid && (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (!have_q) begin
						state_d = end_of_stream ? ST_FLUSH : ST_IDLE;
					end else if (nf_q == NF_BITS'(FIRST_FREE)) begin
						state_d = ST_MISS;
					end else begin
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					state_d = eos_q ? ST_FLUSH : ST_IDLE;
				end else if (last) begin
					state_d = ST_MISS;
				end
			end
			ST_MISS: begin
				if (out_free) begin
					state_d = eos_q ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			dict_mem[nf_q[CODE_BITS-1:0]] <= key;
		end
		rd_s1 <= dict_mem[addr_q[CODE_BITS-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_v_s1    <= 1'b0;
			cmp_idx_s1  <= '0;
			addr_q      <= NF_BITS'(FIRST_FREE);
			nf_q        <= NF_BITS'(FIRST_FREE);
			cur_q       <= '0;
			have_q      <= 1'b0;
			eos_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_v_s1   <= issue;
			cmp_idx_s1 <= addr_q;
			if (acc) begin
				eos_q  <= end_of_stream;
				addr_q <= NF_BITS'(FIRST_FREE);
				if (!have_q) begin
					cur_q  <= CODE_BITS'(data_byte);
					have_q <= 1'b1;
				end
			end
			if (issue) begin
				addr_q <= addr_q + NF_BITS'(1);
			end
			if (hit) begin
				cur_q <= cmp_idx_s1[CODE_BITS-1:0];
			end
			if (ld_miss) begin
				cur_q <= CODE_BITS'(byte_q);
				if (wr_en) begin
					nf_q <= nf_q + NF_BITS'(1);
				end
			end
			if (ld_flush) begin
				nf_q   <= NF_BITS'(FIRST_FREE);
				cur_q  <= '0;
				have_q <= 1'b0;
			end
			if (ld_miss || ld_flush) begin
				out_valid_q <= 1'b1;
			end else if (!code_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			byte_q <= data_byte;
		end
		if (ld_miss || ld_flush) begin
			code_q  <= cur_q;
			final_q <= ld_flush;
		end
	end

	assign code_valid = out_valid_q;
	assign code       = code_q;
	assign final_res  = final_q;

endmodule

[tb/lzw_compressor_core_tb.sv]
// Self-checking testbench of the LZW compressor core: directed table and random streams.
`timescale 1ns / 100ps

module lzw_compressor_core_tb;
	import lzwc_pkg::*;

	localparam int IDLE_PCT        = 19;
	localparam int HOLD_CYCLES     = 200;
	localparam int RANDOM_ITEMS    = 120;
	localparam int DRAIN_CYCLES    = 4000;
	localparam int WATCHDOG_CYCLES = 50000;
	localparam int N_ROWS          = 22;

	typedef struct packed {
		logic [CODE_BITS-1:0] value;
		logic                 fin;
	} code_word_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] value;
		logic                 last;
		logic                 typed;
		logic [1:0]           n_words;
		logic [CODE_BITS-1:0] c0;
		logic                 f0;
		logic [CODE_BITS-1:0] c1;
		logic                 f1;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 byte_valid = 1'b0;
	logic                 byte_stall;
	logic [BYTE_BITS-1:0] data_byte = '0;
	logic                 end_of_stream = 1'b0;
	logic                 code_valid;
	logic                 code_stall = 1'b0;
	logic [CODE_BITS-1:0] code;
	logic                 final_res;

	bit jitter_on = 1'b1;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int fail_count = 0;

	code_word_t awaited_codes[$];

	logic [CODE_BITS-1:0] pair_code [logic [ENTRY_BITS-1:0]];
	logic [NF_BITS-1:0]   dict_next = NF_BITS'(FIRST_FREE);
	logic [CODE_BITS-1:0] prefix_code = '0;
	bit                   prefix_live = 1'b0;

	stim_row_t stim_table [N_ROWS] = '{
		'{8'h00, 1'b1, 1'b1, 2'd1, 12'd0,   1'b1, 12'd0, 1'b0},
		'{8'hFF, 1'b1, 1'b1, 2'd1, 12'd255, 1'b1, 12'd0, 1'b0},
		'{8'h41, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h42, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h41, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h42, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h41, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h42, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h41, 1'b1, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h00, 1'b1, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h55, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h55, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h55, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h55, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h55, 1'b0, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h55, 1'b1, 1'b0, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'hAA, 1'b0, 1'b1, 2'd0, 12'd0,   1'b0, 12'd0, 1'b0},
		'{8'h01, 1'b1, 1'b1, 2'd2, 12'd170, 1'b0, 12'd1, 1'b1}
	};

	lzw_compressor_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.code_valid    (code_valid),
		.code_stall    (code_stall),
		.code          (code),
		.final_res     (final_res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void lzw_encode_byte(input logic [BYTE_BITS-1:0] b, input logic last,
			input bit keep);
		logic [ENTRY_BITS-1:0] key;
		key = {prefix_code, b};
		if (!prefix_live) begin
			prefix_code = CODE_BITS'(b);
			prefix_live = 1'b1;
		end else if (pair_code.exists(key)) begin
			prefix_code = pair_code[key];
		end else begin
			if (keep)
				awaited_codes.push_back(code_word_t'{prefix_code, 1'b0});
			if (dict_next < NF_BITS'(DICT_DEPTH)) begin
				pair_code[key] = dict_next[CODE_BITS-1:0];
				dict_next++;
			end
			prefix_code = CODE_BITS'(b);
		end
		if (last) begin
			if (keep)
				awaited_codes.push_back(code_word_t'{prefix_code, 1'b1});
			pair_code.delete();
			dict_next = NF_BITS'(FIRST_FREE);
			prefix_code = '0;
			prefix_live = 1'b0;
		end
	endfunction

	task automatic offer_byte(input logic [BYTE_BITS-1:0] b, input logic last, input bit keep);
		@(negedge clk);
		while (jitter_on && $urandom_range(0, 99) < IDLE_PCT) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		end_of_stream <= last;
		do @(posedge clk); while (byte_stall !== 1'b0);
		lzw_encode_byte(b, last, keep);
	endtask

	task automatic send_stream(input int len, input bit wide);
		logic [BYTE_BITS-1:0] base;
		logic [BYTE_BITS-1:0] b;
		base = BYTE_BITS'($urandom_range(0, 255));
		for (int k = 0; k < len; k++) begin
			if (wide)
				b = BYTE_BITS'($urandom_range(0, 255));
			else
				b = base + BYTE_BITS'($urandom_range(0, 2));
			offer_byte(b, k == len - 1, 1'b1);
		end
	endtask

	task automatic drain_codes;
		@(negedge clk);
		byte_valid <= 1'b0;
		while (awaited_codes.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				code_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				code_stall <= 1'b1;
			end else begin
				code_stall <= jitter_on && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		code_word_t want;
		if (arst_n && code_valid === 1'b1 && code_stall === 1'b0) begin
			if (awaited_codes.size() == 0) begin
				$error("code: no word awaited, got %0d (final_res %0b)", code, final_res);
				fail_count++;
			end else begin
				want = awaited_codes.pop_front();
				if (code !== want.value) begin
					$error("code: expected %0d, got %0d", want.value, code);
					fail_count++;
				end
				if (final_res !== want.fin) begin
					$error("final_res: expected %0b, got %0b", want.fin, final_res);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((byte_valid && !byte_stall) || (code_valid && !code_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int sent;
		int stream_no;
		int len;
		bit wide;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i]) begin
			offer_byte(stim_table[i].value, stim_table[i].last, !stim_table[i].typed);
			if (stim_table[i].typed) begin
				if (stim_table[i].n_words >= 1)
					awaited_codes.push_back(code_word_t'{stim_table[i].c0, stim_table[i].f0});
				if (stim_table[i].n_words == 2)
					awaited_codes.push_back(code_word_t'{stim_table[i].c1, stim_table[i].f1});
			end
		end
		drain_codes();

		sent = 0;
		stream_no = 0;
		while (sent < RANDOM_ITEMS) begin
			len = $urandom_range(1, 30);
			wide = $urandom_range(0, 99) < 35;
			if (stream_no == 2) begin
				len = 20;
				wide = 1'b1;
				hold_req = 1'b1;
			end
			jitter_on = !(sent >= 60 && sent < 100);
			send_stream(len, wide);
			sent += len;
			stream_no++;
		end
		jitter_on = 1'b1;
		drain_codes();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[lzw_compressor_core.f]
design/lzwc_pkg.sv
design/lzw_compressor_core.sv
tb/lzw_compressor_core_tb.sv
